@@ rtl/clcd_pkg.sv @@
// shared types, constants and helpers for the character lcd write sequencer
// no dependencies
package clcd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_FOUR_BIT  = 2'd0;
  localparam logic [1:0] CFG_UPPER     = 2'd1;
  localparam logic [1:0] CFG_HOLD      = 2'd2;

  localparam logic [15:0] HOLD_RESET   = 16'd50000;

  // input item kinds
  localparam logic [1:0] KIND_CMD      = 2'd0;
  localparam logic [1:0] KIND_DATA     = 2'd1;
  localparam logic [1:0] KIND_CURSOR   = 2'd2;

  localparam logic [7:0] CURSOR_BIT    = 8'h80;

  // pin state steps of one transfer
  localparam logic [2:0] STEP_RS       = 3'd0;
  localparam logic [2:0] STEP_E_HI     = 3'd1;
  localparam logic [2:0] STEP_HI_NIB   = 3'd2;
  localparam logic [2:0] STEP_E_LO     = 3'd3;
  localparam logic [2:0] STEP_E_HI2    = 3'd4;
  localparam logic [2:0] STEP_LO_NIB   = 3'd5;
  localparam logic [2:0] STEP_E_LO2    = 3'd6;

  // decoupling queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef struct packed {
    logic       rs;
    logic [7:0] byte_val;
  } q_entry_t;

  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h10;
      2'd3:    off = 8'h50;
      default: off = 8'h00;
    endcase
    return off;
  endfunction

endpackage

@@ rtl/clcd_front.sv @@
// front end: classifies incoming transactions and forms the byte to send
// depends on clcd_pkg
module clcd_front
  import clcd_pkg::*;
(
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_tuser,   // cmd
  input  logic [15:0] in_tdata,  // value[7:0], row[9:8], col[15:10]
  input  logic       q_full,
  output logic       q_push,
  output q_entry_t   q_wdata
);

  logic [1:0] kind;
  logic [7:0] value;
  logic [1:0] row;
  logic [5:0] col;
  logic       kind_ok;
  logic [7:0] cursor_addr;

  assign kind  = in_tuser;
  assign value = in_tdata[7:0];
  assign row   = in_tdata[9:8];
  assign col   = in_tdata[15:10];

  // address add wraps at 8 bits before the set-address bit
  assign cursor_addr = (row_offset(row) + {2'b00, col}) | CURSOR_BIT;

  always_comb begin
    kind_ok          = 1'b1;
    q_wdata.rs       = 1'b0;
    q_wdata.byte_val = value;
    case (kind)
      KIND_CMD: begin
        q_wdata.rs = 1'b0;
      end
      KIND_DATA: begin
        q_wdata.rs = 1'b1;
      end
      KIND_CURSOR: begin
        q_wdata.byte_val = cursor_addr;
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
  end

  // unused kind is accepted and dropped
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && kind_ok;

endmodule

@@ rtl/clcd_queue.sv @@
// short fifo between the front end and the pin sequencer
// depends on clcd_pkg
module clcd_queue
  import clcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     rvalid,
  output q_entry_t rdata
);

  q_entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;

  assign full   = (count_r == Q_CW'(Q_DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !rvalid |-> !pop)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[Q_AW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

@@ rtl/clcd_back.sv @@
// pin sequencer: expands each queued byte into lcd bus pin states
// depends on clcd_pkg
module clcd_back
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        four_bit_mode,
  input  logic        upper_pins,
  input  logic [15:0] pin_hold_cycles,
  input  logic        q_valid,
  input  q_entry_t    q_rdata,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // reg_select[0], read_write[1], enable[2], data_bus[10:3]
  output logic        out_tlast   // last
);

  logic        busy_r, busy_nxt;
  logic [2:0]  step_r, step_nxt;
  q_entry_t    cur_r, cur_nxt;
  logic [7:0]  dport_r, dport_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic        o_rs_r, o_rs_nxt;
  logic        o_en_r, o_en_nxt;
  logic        o_last_r, o_last_nxt;

  logic        can_load;
  logic        load;
  q_entry_t    src;
  logic [2:0]  src_step;
  logic        step_en;
  logic        step_last;
  logic [3:0]  nib;

  assign can_load = (!ovalid_r || out_tready) && (hold_r == '0);
  assign load     = can_load && (busy_r || q_valid);
  assign q_pop    = can_load && !busy_r && q_valid;

  assign src      = busy_r ? cur_r : q_rdata;
  assign src_step = busy_r ? step_r : STEP_RS;

  always_comb begin
    case (src_step)
      STEP_RS:     step_en = 1'b0;
      STEP_E_HI:   step_en = 1'b1;
      STEP_HI_NIB: step_en = 1'b1;
      STEP_E_LO:   step_en = 1'b0;
      STEP_E_HI2:  step_en = 1'b1;
      STEP_LO_NIB: step_en = 1'b1;
      STEP_E_LO2:  step_en = 1'b0;
      default:     step_en = 1'b0;
    endcase
  end

  assign step_last = four_bit_mode ? (src_step == STEP_E_LO2) : (src_step == STEP_E_LO);

  // nibble writes keep the other half of the port
  always_comb begin
    nib       = (src_step == STEP_HI_NIB) ? src.byte_val[7:4] : src.byte_val[3:0];
    dport_nxt = dport_r;
    if (load) begin
      if (four_bit_mode) begin
        if (src_step == STEP_HI_NIB || src_step == STEP_LO_NIB) begin
          dport_nxt = upper_pins ? {nib, dport_r[3:0]} : {dport_r[7:4], nib};
        end
      end else if (src_step == STEP_HI_NIB) begin
        dport_nxt = src.byte_val;
      end
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    step_nxt   = step_r;
    cur_nxt    = cur_r;
    ovalid_nxt = ovalid_r;
    o_rs_nxt   = o_rs_r;
    o_en_nxt   = o_en_r;
    o_last_nxt = o_last_r;
    hold_nxt   = (hold_r != '0) ? hold_r - 1'b1 : hold_r;
    if (load) begin
      cur_nxt    = src;
      busy_nxt   = !step_last;
      step_nxt   = step_last ? STEP_RS : src_step + 1'b1;
      ovalid_nxt = 1'b1;
      o_rs_nxt   = src.rs;
      o_en_nxt   = step_en;
      o_last_nxt = step_last;
      // the hold counter, loaded from pin_hold_cycles, keeps each pin state up before the next one
      hold_nxt   = (pin_hold_cycles != '0) ? pin_hold_cycles - 1'b1 : '0;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      step_r   <= STEP_RS;
      dport_r  <= '0;
      hold_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      step_r   <= step_nxt;
      dport_r  <= dport_nxt;
      hold_r   <= hold_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    o_rs_r   <= o_rs_nxt;
    o_en_r   <= o_en_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'b00000, dport_r, o_en_r, 1'b0, o_rs_r};
  assign out_tlast  = o_last_r;

`ifndef ASSERT_OFF
  a_busy_mid_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r != STEP_RS))
    else $error("sequencer busy at first step");

  a_last_e_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> !out_tdata[2])
    else $error("transfer ends with E high");

  a_stall_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("pin state changed while stalled");

  a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !q_pop)
    else $error("queue popped mid transfer");
`endif

endmodule

@@ rtl/char_lcd_bus_write_sequencer_top.sv @@
// path: an accepted transaction goes into the queue, then its first pin state is registered
// steps: 7 pin states per transfer in 4-bit mode, 4 in 8-bit mode, each held by the hold
//   counter in the sequencer; a 4-entry queue lets the input keep flowing while the
//   sequencer works
// reset: rst_n synchronous active low; config returns to 4-bit, upper pins, hold
//   50000, data port cleared; depends on clcd_pkg, clcd_front, clcd_queue, clcd_back
module char_lcd_bus_write_sequencer_top
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [15:0] in_tdata,   // value[7:0], row[9:8], col[15:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // reg_select[0], read_write[1], enable[2], data_bus[10:3]
  output logic        out_tlast   // last
);

  logic        four_bit_r, four_bit_nxt;
  logic        upper_r, upper_nxt;
  logic [15:0] hold_cfg_r, hold_cfg_nxt;

  logic        q_full;
  logic        q_push;
  q_entry_t    q_wdata;
  logic        q_pop;
  logic        q_valid;
  q_entry_t    q_rdata;

  always_comb begin
    four_bit_nxt = four_bit_r;
    upper_nxt    = upper_r;
    hold_cfg_nxt = hold_cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_FOUR_BIT: four_bit_nxt = cfg_wdata[0];
        CFG_UPPER:    upper_nxt    = cfg_wdata[0];
        CFG_HOLD:     hold_cfg_nxt = cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r <= 1'b1;
      upper_r    <= 1'b1;
      hold_cfg_r <= HOLD_RESET;
    end else begin
      four_bit_r <= four_bit_nxt;
      upper_r    <= upper_nxt;
      hold_cfg_r <= hold_cfg_nxt;
    end
  end

  clcd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  clcd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  clcd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .four_bit_mode   (four_bit_r),
    .upper_pins      (upper_r),
    .pin_hold_cycles (hold_cfg_r),
    .q_valid         (q_valid),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast)
  );

endmodule

@@ bench/clcd_pin_checker.sv @@
`timescale 1ns / 1ps
// watches the config port and both streams of the lcd write sequencer, predicts every
// pin state and compares it with what leaves the block; depends on clcd_pkg
module clcd_pin_checker
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [15:0] in_tdata,   // value[7:0], row[9:8], col[15:10]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // reg_select[0], read_write[1], enable[2], data_bus[10:3]
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count,
  output int          states_checked
);

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [7:0] bus;
    logic       last;
  } pin_state_t;

  logic       nibble_mode;
  logic       nibble_upper;
  logic [7:0] port_value;
  pin_state_t pending_pins[$];

  function automatic logic [7:0] line_start(input logic [1:0] row);
    logic [7:0] addr;
    case (row)
      2'd0: addr = 8'h00;
      2'd1: addr = 8'h40;
      2'd2: addr = 8'h10;
      default: addr = 8'h50;
    endcase
    return addr;
  endfunction

  function automatic void push_pins(input logic rs, input logic en, input logic fin);
    pin_state_t s;
    s = {rs, 1'b0, en, port_value, fin};
    pending_pins.push_back(s);
  endfunction

  // a nibble only overwrites its half of the port
  function automatic void put_nibble(input logic [3:0] nib);
    if (nibble_upper) port_value[7:4] = nib;
    else port_value[3:0] = nib;
  endfunction

  function automatic void predict_transfer(input logic [1:0] kind, input logic [15:0] bits);
    logic [7:0] code;
    logic       rs;
    case (kind)
      KIND_CMD: begin
        code = bits[7:0];
        rs = 1'b0;
      end
      KIND_DATA: begin
        code = bits[7:0];
        rs = 1'b1;
      end
      KIND_CURSOR: begin
        code = (line_start(bits[9:8]) + {2'b00, bits[15:10]}) | CURSOR_BIT;
        rs = 1'b0;
      end
      default: return;
    endcase
    push_pins(rs, 1'b0, 1'b0);
    push_pins(rs, 1'b1, 1'b0);
    if (nibble_mode) begin
      put_nibble(code[7:4]);
      push_pins(rs, 1'b1, 1'b0);
      push_pins(rs, 1'b0, 1'b0);
      push_pins(rs, 1'b1, 1'b0);
      put_nibble(code[3:0]);
      push_pins(rs, 1'b1, 1'b0);
      push_pins(rs, 1'b0, 1'b1);
    end else begin
      port_value = code;
      push_pins(rs, 1'b1, 1'b0);
      push_pins(rs, 1'b0, 1'b1);
    end
  endfunction

  always @(posedge clk) begin
    pin_state_t got;
    pin_state_t want;
    if (!rst_n) begin
      nibble_mode = 1'b1;
      nibble_upper = 1'b1;
      port_value = 8'h00;
      pending_pins.delete();
      fail_count = 0;
      states_checked = 0;
    end else begin
      // hold time only shapes timing, so only the mode bits are tracked
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FOUR_BIT: nibble_mode = cfg_wdata[0];
          CFG_UPPER: nibble_upper = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_transfer(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[1], out_tdata[2], out_tdata[10:3], out_tlast};
        if (pending_pins.size() == 0) begin
          fail_count++;
          $display("%0t: expected no pin state, got rs=%0b rw=%0b e=%0b bus=%02h last=%0b",
                   $time, got.rs, got.rw, got.en, got.bus, got.last);
        end else begin
          want = pending_pins.pop_front();
          states_checked++;
          if (got !== want) begin
            fail_count++;
            $display("%0t: expected rs=%0b rw=%0b e=%0b bus=%02h last=%0b,",
                     $time, want.rs, want.rw, want.en, want.bus, want.last);
            $display("%0t:      got rs=%0b rw=%0b e=%0b bus=%02h last=%0b",
                     $time, got.rs, got.rw, got.en, got.bus, got.last);
          end
        end
      end
    end
    pending_count <= pending_pins.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for the character lcd write sequencer: directed and random
// transfers over several register settings; depends on clcd_pkg and clcd_pin_checker
module tb;
  import clcd_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  int          fail_count;
  int          pending_count;
  int          states_checked;

  logic [15:0] hold_now = HOLD_RESET;
  bit          calm = 1'b0;
  int          n_cmd = 0;
  int          n_data = 0;
  int          n_cursor = 0;
  int          n_ignored = 0;
  int          n_writes = 0;

  char_lcd_bus_write_sequencer_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  clcd_pin_checker pin_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .fail_count(fail_count), .pending_count(pending_count), .states_checked(states_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // receiver backpressure in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  function automatic logic [15:0] pack_item(input logic [7:0] value, input logic [1:0] row,
                                            input logic [5:0] col);
    return {col, row, value};
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_HOLD) hold_now = val;
    n_writes++;
  endtask

  // block is idle once every pin state is back and the last hold has run out
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (hold_now + 20) @(posedge clk);
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [15:0] bits);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= bits;
    do @(posedge clk); while (!in_tready);
    case (kind)
      KIND_CMD: n_cmd++;
      KIND_DATA: n_data++;
      KIND_CURSOR: n_cursor++;
      default: n_ignored++;
    endcase
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic random_items(input int count, input bit quiet_tail);
    int          sent;
    int          pick;
    logic [1:0]  kind;
    logic [15:0] bits;
    sent = 0;
    while (sent < count) begin
      if (quiet_tail && count - sent <= 15) calm = 1'b1;
      pick = $urandom_range(0, 15);
      kind = (pick < 5) ? KIND_CMD : (pick < 10) ? KIND_DATA :
             (pick < 15) ? KIND_CURSOR : KIND_UNUSED;
      bits = 16'($urandom);
      if ($urandom_range(0, 7) == 0) bits[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      send_item(kind, bits);
      if (kind != KIND_UNUSED) sent++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nibble mode on the upper pins, as after reset
    write_reg(CFG_HOLD, 16'd1);
    send_item(KIND_CMD, pack_item(8'h00, 2'd0, 6'd0));
    send_item(KIND_CMD, pack_item(8'hFF, 2'd3, 6'd63));
    send_item(KIND_DATA, pack_item(8'hA5, 2'd1, 6'd21));
    send_item(KIND_DATA, pack_item(8'hFF, 2'd0, 6'd0));
    send_item(KIND_CURSOR, pack_item(8'hFF, 2'd0, 6'd0));
    send_item(KIND_CURSOR, pack_item(8'h00, 2'd1, 6'd63));
    send_item(KIND_CURSOR, pack_item(8'h5A, 2'd2, 6'd5));
    send_item(KIND_CURSOR, pack_item(8'h00, 2'd3, 6'd63));
    send_item(KIND_UNUSED, 16'hFFFF);
    send_item(KIND_DATA, pack_item(8'h00, 2'd3, 6'd63));

    // lower pins keep the upper half left by the earlier transfers
    settle();
    write_reg(CFG_UPPER, 16'd0);
    send_item(KIND_DATA, pack_item(8'h3C, 2'd0, 6'd0));
    send_item(KIND_CMD, pack_item(8'hC3, 2'd2, 6'd17));
    send_item(KIND_CURSOR, pack_item(8'h00, 2'd1, 6'd42));

    // byte mode at the longest hold
    settle();
    write_reg(CFG_FOUR_BIT, 16'd0);
    write_reg(CFG_HOLD, 16'hFFFF);
    send_item(KIND_DATA, pack_item(8'h5A, 2'd0, 6'd0));
    settle();
    write_reg(CFG_HOLD, 16'd2);
    send_item(KIND_CMD, pack_item(8'h01, 2'd0, 6'd0));
    send_item(KIND_DATA, pack_item(8'hFF, 2'd3, 6'd63));
    send_item(KIND_CURSOR, pack_item(8'hFF, 2'd3, 6'd0));
    send_item(KIND_UNUSED, 16'h0000);

    for (int p = 0; p < 5; p++) begin
      settle();
      write_reg(CFG_FOUR_BIT, (p % 2 == 0) ? 16'd1 : 16'd0);
      write_reg(CFG_UPPER, (p == 2 || p == 3) ? 16'd0 : 16'd1);
      write_reg(CFG_HOLD, 16'($urandom_range(1, 4)));
      random_items(41, p == 4);
    end

    settle();
    $display("sent %0d command, %0d data and %0d cursor transfers, %0d ignored items",
             n_cmd, n_data, n_cursor, n_ignored);
    $display("compared %0d pin states, %0d register writes", states_checked, n_writes);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ char_lcd_bus_write_sequencer_top.f @@
rtl/clcd_pkg.sv
rtl/clcd_front.sv
rtl/clcd_queue.sv
rtl/clcd_back.sv
rtl/char_lcd_bus_write_sequencer_top.sv
bench/clcd_pin_checker.sv
bench/tb.sv
